// File: rtl/smpe_pkg.sv
// Shared types and constants for the serial mouse packet encoder.
// Used by smpe_core, smpe_out_fifo and serial_mouse_packet_encoder; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smpe_pkg;

  // Input item kinds carried on in_tuser.
  localparam logic ACTION_EVENT = 1'b0;
  localparam logic ACTION_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_HEAD_GAP = 1'b0;
  localparam logic REG_TAIL_GAP = 1'b1;

  // Protocol constants.
  localparam logic [2:0] BTN_NONE_HELD = 3'd7;
  localparam logic [7:0] HEAD_FLAG    = 8'h80;
  localparam logic [7:0] ACC_POS_SAT  = 8'h7F;   // +127
  localparam logic [7:0] ACC_NEG_SAT  = 8'h81;   // -127
  localparam logic [7:0] HEAD_GAP_RST = 8'd25;
  localparam logic [7:0] TAIL_GAP_RST = 8'd15;
  localparam logic [7:0] GAP_RST      = 8'd40;
  localparam logic [7:0] ELAPSED_MAX  = 8'hFF;

  // Output byte queue geometry.
  localparam int OB_DEPTH  = 8;
  localparam int OB_PTR_W  = 3;
  localparam int OB_CNT_W  = 4;
  localparam int PART_MAX  = 3;

  typedef logic [OB_PTR_W-1:0] ob_ptr_t;
  typedef logic [OB_CNT_W-1:0] ob_cnt_t;

  // One queued output byte.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } ob_entry_t;

  // Bytes of one packet part handed from the core to the queue.
  typedef struct packed {
    logic [1:0]                   cnt;
    ob_entry_t [PART_MAX-1:0]     ent;
  } part_push_t;

endpackage

`default_nettype wire

// File: rtl/smpe_core.sv
// Input register, encoder state and per-item update logic of the mouse packet encoder.
// Depends on smpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smpe_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic                  cfg_index,
  input  wire logic [7:0]            cfg_data,
  input  wire logic                  item_load,
  input  wire logic                  action,
  input  wire logic                  left_pressed,
  input  wire logic                  middle_pressed,
  input  wire logic                  right_pressed,
  input  wire logic [7:0]            move_x,
  input  wire logic [7:0]            move_y,
  output logic                       stage_valid,
  output smpe_pkg::part_push_t       push
);

  // Clamp a widened sum to the accumulator range of -127..127.
  function automatic logic [7:0] sat_acc(input logic signed [9:0] v);
    logic [7:0] res;
    if (v > 10'sd127) begin
      res = smpe_pkg::ACC_POS_SAT;
    end else if (v < -10'sd127) begin
      res = smpe_pkg::ACC_NEG_SAT;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  logic       valid_r;
  logic       action_r;
  logic       left_r, middle_r, right_r;
  logic [7:0] move_x_r, move_y_r;

  logic [7:0] head_gap_r, tail_gap_r;
  logic [7:0] acc_x_r, acc_x_nxt;
  logic [7:0] acc_y_r, acc_y_nxt;
  logic [2:0] code_r, code_nxt;
  logic       pending_r, pending_nxt;
  logic       in_tail_r, in_tail_nxt;
  logic [7:0] gap_r, gap_nxt;
  logic [7:0] elapsed_r, elapsed_nxt;

  logic signed [9:0] sum_x, sum_y;
  logic [7:0]        el_inc;

  // Input register: one beat per cycle while item_load is high, payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= item_load;
    end
    if (item_load) begin
      action_r <= action;
      left_r   <= left_pressed;
      middle_r <= middle_pressed;
      right_r  <= right_pressed;
      move_x_r <= move_x;
      move_y_r <= move_y;
    end
  end

  assign stage_valid = valid_r;

  // Gap registers written from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_gap_r <= smpe_pkg::HEAD_GAP_RST;
      tail_gap_r <= smpe_pkg::TAIL_GAP_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == smpe_pkg::REG_HEAD_GAP) begin
        head_gap_r <= cfg_data;
      end else begin
        tail_gap_r <= cfg_data;
      end
    end
  end

  // Widened sums; the vertical delta is negated before it is added.
  assign sum_x = {{2{acc_x_r[7]}}, acc_x_r} + {{2{move_x_r[7]}}, move_x_r};
  assign sum_y = {{2{acc_y_r[7]}}, acc_y_r} - {{2{move_y_r[7]}}, move_y_r};
  assign el_inc = (elapsed_r == smpe_pkg::ELAPSED_MAX) ? smpe_pkg::ELAPSED_MAX
                                                       : elapsed_r + 8'd1;

  // Per-item update and packet part assembly.
  always_comb begin
    acc_x_nxt   = acc_x_r;
    acc_y_nxt   = acc_y_r;
    code_nxt    = code_r;
    pending_nxt = pending_r;
    in_tail_nxt = in_tail_r;
    gap_nxt     = gap_r;
    elapsed_nxt = elapsed_r;
    push        = '0;
    if (valid_r) begin
      if (action_r == smpe_pkg::ACTION_EVENT) begin
        code_nxt    = {~left_r, ~middle_r, ~right_r};
        acc_x_nxt   = sat_acc(sum_x);
        acc_y_nxt   = sat_acc(sum_y);
        pending_nxt = 1'b1;
      end else if (el_inc < gap_r) begin
        elapsed_nxt = el_inc;
      end else begin
        elapsed_nxt = el_inc - gap_r;
        if (pending_r) begin
          acc_x_nxt = '0;
          acc_y_nxt = '0;
          if (!in_tail_r) begin
            // Head part: status byte, then both deltas.
            push.cnt         = 2'd3;
            push.ent[0].data = smpe_pkg::HEAD_FLAG | {5'd0, code_r};
            push.ent[1].data = acc_x_r;
            push.ent[2].data = acc_y_r;
            push.ent[2].last = 1'b1;
            code_nxt         = smpe_pkg::BTN_NONE_HELD;
            in_tail_nxt      = 1'b1;
            gap_nxt          = head_gap_r;
          end else begin
            // Tail part: deltas gathered since the head.
            push.cnt         = 2'd2;
            push.ent[0].data = acc_x_r;
            push.ent[1].data = acc_y_r;
            push.ent[1].last = 1'b1;
            in_tail_nxt      = 1'b0;
            gap_nxt          = tail_gap_r;
            pending_nxt      = (code_r != smpe_pkg::BTN_NONE_HELD);
          end
        end
      end
    end
  end

  // Encoder state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r   <= '0;
      acc_y_r   <= '0;
      code_r    <= smpe_pkg::BTN_NONE_HELD;
      pending_r <= 1'b0;
      in_tail_r <= 1'b0;
      gap_r     <= smpe_pkg::GAP_RST;
      elapsed_r <= '0;
    end else begin
      acc_x_r   <= acc_x_nxt;
      acc_y_r   <= acc_y_nxt;
      code_r    <= code_nxt;
      pending_r <= pending_nxt;
      in_tail_r <= in_tail_nxt;
      gap_r     <= gap_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/smpe_out_fifo.sv
// Output byte queue: takes up to three bytes of a packet part per cycle, drains one per beat.
// Depends on smpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smpe_out_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire smpe_pkg::part_push_t  push,
  input  wire logic                  pop,
  output smpe_pkg::ob_cnt_t          count,
  output smpe_pkg::ob_entry_t        head
);

  smpe_pkg::ob_entry_t mem_r [smpe_pkg::OB_DEPTH];
  smpe_pkg::ob_ptr_t   wr_ptr_r, wr_ptr_nxt;
  smpe_pkg::ob_ptr_t   rd_ptr_r, rd_ptr_nxt;
  smpe_pkg::ob_cnt_t   count_r, count_nxt;

  // Pointer and fill-count arithmetic.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + smpe_pkg::ob_ptr_t'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + smpe_pkg::ob_ptr_t'(pop);
    count_nxt  = count_r + smpe_pkg::ob_cnt_t'(push.cnt) - smpe_pkg::ob_cnt_t'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage: the part's bytes land in consecutive slots.
  always_ff @(posedge clk) begin
    for (int i = 0; i < smpe_pkg::PART_MAX; i++) begin
      if (i < int'(push.cnt)) begin
        mem_r[wr_ptr_r + smpe_pkg::ob_ptr_t'(i)] <= push.ent[i];
      end
    end
  end

  assign count = count_r;
  assign head  = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// File: rtl/serial_mouse_packet_encoder.sv
// Top level of the serial mouse packet encoder (five-byte serial mouse protocol).
// Depends on smpe_pkg, smpe_core and smpe_out_fifo.
//
// Usage:
//   The in_ stream carries mouse events (in_tuser = 0) and millisecond ticks
//   (in_tuser = 1). Events update buttons and motion; ticks pace the output.
//   The out_ stream carries the serial bytes, one per beat, with out_tlast on
//   the final byte of each head (three bytes) or tail (two bytes) part.
//   The cfg_ port writes the head gap (index 0) and tail gap (index 1).
//   A taken beat is held in the input register, its part is pushed into the
//   output queue, and its first byte is offered on out_ from the queue head.
//   Throughput: one input beat per cycle while the eight-byte output queue has
//   room for the parts still in flight; in_tready drops when more than five
//   bytes (two with a beat in the input register) are waiting.
//   A stalled receiver only fills the queue; no byte is lost or reordered.
//   Reset clears the queue and loads the gaps with 25 and 15 ticks, the
//   first gap with 40 ticks and the button code with no buttons held.
`timescale 1ns / 1ps
`default_nettype none

module serial_mouse_packet_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [0] left_pressed, [1] middle_pressed, [2] right_pressed, [10:3] move_x,
  // [18:11] move_y, [23:19] zero
  input  wire logic [23:0] in_tdata,
  // [0] action
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] tx_byte
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);

  logic                 in_accept;
  logic                 stage_valid;
  logic                 pop;
  smpe_pkg::part_push_t push;
  smpe_pkg::ob_cnt_t    ob_count;
  smpe_pkg::ob_cnt_t    committed;
  smpe_pkg::ob_entry_t  ob_head;

  // Room check: the beat in the input register and the new one may each add a part.
  assign committed = ob_count + (stage_valid ? smpe_pkg::ob_cnt_t'(smpe_pkg::PART_MAX)
                                             : '0);
  assign in_tready = (committed <= smpe_pkg::ob_cnt_t'(smpe_pkg::OB_DEPTH - smpe_pkg::PART_MAX));
  assign in_accept = in_tvalid && in_tready;

  smpe_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_load      (in_accept),
    .action         (in_tuser),
    .left_pressed   (in_tdata[0]),
    .middle_pressed (in_tdata[1]),
    .right_pressed  (in_tdata[2]),
    .move_x         (in_tdata[10:3]),
    .move_y         (in_tdata[18:11]),
    .stage_valid    (stage_valid),
    .push           (push)
  );

  // Output side of the queue.
  assign out_tvalid = (ob_count != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = ob_head.data;
  assign out_tlast  = ob_head.last;

  smpe_out_fifo u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .count (ob_count),
    .head  (ob_head)
  );

  // The queue never takes more bytes than it has slots.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, ob_count} + {3'b0, push.cnt}) <= 5'(smpe_pkg::OB_DEPTH))
    else $error("output queue overflow");

  // A part is either a head of three bytes or a tail of two.
  a_part_len: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd1)
    else $error("single-byte part pushed");

  // A head part starts with the sync pattern 10000 in its upper five bits.
  a_head_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd3) |-> (push.ent[0].data[7:3] == 5'b10000))
    else $error("head part without sync pattern");

endmodule

`default_nettype wire
